### hw/rtl/assert_macros.svh
// Assertion helpers for the verification-side checker of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/rne_pkg.sv
package rne_pkg;

	// Field widths.
	localparam int VALUE_W     = 12;
	localparam int CHAR_W      = 7;
	localparam int STATUS_W    = 2;
	localparam int SYM_IDX_W   = 4;
	localparam int NUM_SYMBOLS = 13;

	// Largest value that has a numeral.
	localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

	// Status codes of a result word.
	localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_NUMERAL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_TOO_LARGE  = 2'd2;

	// ASCII codes of the numeral letters; CH_NONE marks "no letter".
	localparam logic [CHAR_W-1:0] CH_NONE = 7'h00;
	localparam logic [CHAR_W-1:0] CH_I    = 7'h49;
	localparam logic [CHAR_W-1:0] CH_V    = 7'h56;
	localparam logic [CHAR_W-1:0] CH_X    = 7'h58;
	localparam logic [CHAR_W-1:0] CH_L    = 7'h4C;
	localparam logic [CHAR_W-1:0] CH_C    = 7'h43;
	localparam logic [CHAR_W-1:0] CH_D    = 7'h44;
	localparam logic [CHAR_W-1:0] CH_M    = 7'h4D;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
	} rne_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic slot_free;
		logic last_char;
	} rne_sts_t;

	// Value of each table symbol, largest first.
	function automatic logic [VALUE_W-1:0] sym_value(input logic [SYM_IDX_W-1:0] idx);
		logic [VALUE_W-1:0] v;
		case (idx)
			4'd0:    v = 12'd1000;
			4'd1:    v = 12'd900;
			4'd2:    v = 12'd500;
			4'd3:    v = 12'd400;
			4'd4:    v = 12'd100;
			4'd5:    v = 12'd90;
			4'd6:    v = 12'd50;
			4'd7:    v = 12'd40;
			4'd8:    v = 12'd10;
			4'd9:    v = 12'd9;
			4'd10:   v = 12'd5;
			4'd11:   v = 12'd4;
			default: v = 12'd1;
		endcase
		return v;
	endfunction

	// First letter of each table symbol.
	function automatic logic [CHAR_W-1:0] sym_first(input logic [SYM_IDX_W-1:0] idx);
		logic [CHAR_W-1:0] c;
		case (idx)
			4'd0:    c = CH_M;
			4'd1:    c = CH_C;
			4'd2:    c = CH_D;
			4'd3:    c = CH_C;
			4'd4:    c = CH_C;
			4'd5:    c = CH_X;
			4'd6:    c = CH_L;
			4'd7:    c = CH_X;
			4'd8:    c = CH_X;
			4'd9:    c = CH_I;
			4'd10:   c = CH_V;
			default: c = CH_I;
		endcase
		return c;
	endfunction

	// Second letter of each table symbol, CH_NONE for single letters.
	function automatic logic [CHAR_W-1:0] sym_second(input logic [SYM_IDX_W-1:0] idx);
		logic [CHAR_W-1:0] c;
		case (idx)
			4'd1:    c = CH_M;
			4'd3:    c = CH_D;
			4'd5:    c = CH_C;
			4'd7:    c = CH_L;
			4'd9:    c = CH_X;
			4'd11:   c = CH_V;
			default: c = CH_NONE;
		endcase
		return c;
	endfunction

	// Index of the largest symbol not above rem. The compares are independent;
	// the lowest matching index wins.
	function automatic logic [SYM_IDX_W-1:0] pick_symbol(input logic [VALUE_W-1:0] rem);
		logic [SYM_IDX_W-1:0] idx;
		idx = SYM_IDX_W'(NUM_SYMBOLS - 1);
		for (int i = NUM_SYMBOLS - 1; i >= 0; i--) begin
			if (rem >= sym_value(SYM_IDX_W'(i))) begin
				idx = SYM_IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

### hw/rtl/rne_datapath.sv
module rne_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rne_pkg::rne_cmd_t                cmd,
	output rne_pkg::rne_sts_t                sts,
	input  logic [rne_pkg::VALUE_W-1:0]      value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [rne_pkg::CHAR_W-1:0]       char_code,
	output logic                             last,
	output logic [rne_pkg::STATUS_W-1:0]     status
);
	import rne_pkg::*;

	logic [VALUE_W-1:0]   remaining_q;
	logic [SYM_IDX_W-1:0] symbol_index_q;
	logic                 pending_q;
	logic [STATUS_W-1:0]  err_q;

	logic [SYM_IDX_W-1:0] pick_idx;
	logic [VALUE_W-1:0]   rem_after;
	logic [CHAR_W-1:0]    pick_second;
	logic [CHAR_W-1:0]    nxt_char;
	logic                 nxt_last;

	logic                 out_valid_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 last_q;
	logic [STATUS_W-1:0]  status_q;

	// Greedy symbol choice and the letter it yields this step.
	always_comb begin
		pick_idx    = pick_symbol(remaining_q);
		rem_after   = remaining_q - sym_value(pick_idx);
		pick_second = sym_second(pick_idx);
		if (err_q != STAT_OK) begin
			nxt_char = CH_NONE;
			nxt_last = 1'b1;
		end else if (pending_q) begin
			nxt_char = sym_second(symbol_index_q);
			nxt_last = (remaining_q == '0);
		end else if (pick_second != CH_NONE) begin
			nxt_char = sym_first(pick_idx);
			nxt_last = 1'b0;
		end else begin
			nxt_char = sym_first(pick_idx);
			nxt_last = (rem_after == '0);
		end
	end

	// Encoding state: loaded with a new word, advanced once per emitted letter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (cmd.load) begin
			pending_q <= 1'b0;
		end else if (cmd.step && err_q == STAT_OK) begin
			pending_q <= !pending_q && (pick_second != CH_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			remaining_q <= value;
			if (value == '0) begin
				err_q <= STAT_NO_NUMERAL;
			end else if (value > MAX_VALUE) begin
				err_q <= STAT_TOO_LARGE;
			end else begin
				err_q <= STAT_OK;
			end
		end else if (cmd.step && err_q == STAT_OK && !pending_q) begin
			remaining_q    <= rem_after;
			symbol_index_q <= pick_idx;
		end
	end

	// Output register: filled on a step, emptied when the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			char_q   <= nxt_char;
			last_q   <= nxt_last;
			status_q <= err_q;
		end
	end

	assign sts.slot_free = !out_valid_q || out_ready;
	assign sts.last_char = nxt_last;

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;
	assign status    = status_q;

endmodule

### hw/rtl/rne_ctrl.sv
module rne_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output rne_pkg::rne_cmd_t cmd,
	input  rne_pkg::rne_sts_t sts
);
	import rne_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic state_q;
	logic state_nxt;

	// Commands: load on accept, step in the run state whenever the output slot can take a word.
	assign in_ready = (state_q == S_IDLE);
	assign cmd.load = in_valid && in_ready;
	assign cmd.step = (state_q == S_RUN) && sts.slot_free;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.load) begin
					state_nxt = S_RUN;
				end
			end
			S_RUN: begin
				if (cmd.step && sts.last_char) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

### hw/rtl/roman_numeral_encoder.sv
// Roman numeral encoder.
// Input channel (in_valid/in_ready, value): one word is a 12-bit unsigned number.
// Output channel (out_valid/out_ready, char_code/last/status): one word per
// upper-case ASCII letter of the numeral, last set on its final letter.
// A zero input gives a single word with char_code 0, last 1, status 1; an
// input above 3999 gives a single word with char_code 0, last 1, status 2.
// After the input is taken, the controller steps the datapath, which emits one
// letter per cycle into the output register while the receiver does not stall;
// a numeral has at most 15 letters. The greedy table search and the subtraction
// are combinational.
// The input is taken again as soon as the final letter sits in the output
// register, so the next number can load while that letter waits.
// If the receiver stalls, the output register holds its word and the encoder
// waits with it; no letter is lost or repeated.
// Reset (arst_n low) empties the output register and returns the controller
// to idle; any numeral in progress is dropped.
module roman_numeral_encoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rne_pkg::VALUE_W-1:0]      value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [rne_pkg::CHAR_W-1:0]       char_code,
	output logic                             last,
	output logic [rne_pkg::STATUS_W-1:0]     status
);
	import rne_pkg::*;

	rne_cmd_t cmd;
	rne_sts_t sts;

	// Sequencer.
	rne_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Encoding state, symbol table lookup and output register.
	rne_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.last      (last),
		.status    (status)
	);

endmodule

### hw/rtl/rne_checker.sv
`include "assert_macros.svh"

module rne_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [rne_pkg::CHAR_W-1:0]       char_code,
	input logic                             last,
	input logic [rne_pkg::STATUS_W-1:0]     status
);
	import rne_pkg::*;

	logic                         stalled;
	logic                         is_error;
	logic                         is_letter;
	logic                         known_status;
	logic [CHAR_W+STATUS_W:0]     out_word;

	// Output word as one bus, and a few views of what it carries.
	assign stalled      = out_valid && !out_ready;
	assign is_error     = out_valid && (status != STAT_OK);
	assign out_word     = {char_code, last, status};
	assign is_letter    = (char_code == CH_I) || (char_code == CH_V) ||
			(char_code == CH_X) || (char_code == CH_L) ||
			(char_code == CH_C) || (char_code == CH_D) ||
			(char_code == CH_M);
	assign known_status = (status == STAT_OK) || (status == STAT_NO_NUMERAL) ||
			(status == STAT_TOO_LARGE);

	// A stalled output word holds still.
	`ASSERT_NXT(a_out_hold, stalled, out_valid && $stable(out_word), "stalled word changed")

	// An error word is a lone, final word with no letter.
	`ASSERT_IMP(a_err_word, is_error, last && char_code == CH_NONE, "bad error word")

	// A good word carries one of the seven numeral letters.
	`ASSERT_IMP(a_letter, out_valid && status == STAT_OK, is_letter, "not a numeral letter")

	// Once a number is taken, the encoder is busy with it in the next cycle.
	`ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input taken while encoding")

	// No status code beyond the three defined ones.
	`ASSERT_IMP(a_status_code, out_valid, known_status, "unknown status code")

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (.*);
